>>> src/urif_pkg.sv
// ----------------------------------------------------------------------------
// urif_pkg
// Shared constants, codes and types of the idle-delimited receive ring.
// ----------------------------------------------------------------------------
package urif_pkg;

    // ring store
    localparam int RING_DEPTH    = 1024;
    localparam int ADDR_W        = $clog2(RING_DEPTH);

    // writer-behind-reader distance that forces a frame close
    localparam int NEAR_FULL_GAP = 10;
    localparam int NF_W          = ADDR_W + 9;

    // read burst
    localparam int MAX_BURST     = 64;
    localparam int CNT_W         = 7;

    // idle timer
    localparam int IDLE_W                  = 20;
    localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};
    localparam logic [IDLE_W-1:0] IDLE_LIMIT_RST = IDLE_W'((84000000 / 9) / 100);

    // read command queue between front and back
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic [1:0] {
        REQ_BYTE = 2'd0,
        REQ_TICK = 2'd1,
        REQ_READ = 2'd2
    } t_req_type;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  count;
    } t_rd_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_cmdq_stat;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             has_byte;
        logic             last_of_read;
        logic [CNT_W-1:0] read_total;
    } t_result;

endpackage

>>> src/urif_ifs.sv
// ----------------------------------------------------------------------------
// urif channel interfaces
// Valid/ready channels for requests, results and the idle limit register.
// ----------------------------------------------------------------------------
interface urif_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] rx_byte;
    logic [6:0] max_read;

    modport source (output valid, output req_type, output rx_byte, output max_read,
                    input ready);
    modport sink   (input valid, input req_type, input rx_byte, input max_read,
                    output ready);
endinterface

interface urif_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       last_of_read;
    logic [6:0] read_total;

    modport source (output valid, output out_byte, output has_byte,
                    output last_of_read, output read_total, input ready);
    modport sink   (input valid, input out_byte, input has_byte,
                    input last_of_read, input read_total, output ready);
endinterface

interface urif_cfg_if;
    logic        valid;
    logic        ready;
    logic [19:0] idle_limit;

    modport source (output valid, output idle_limit, input ready);
    modport sink   (input valid, input idle_limit, output ready);
endinterface

>>> src/urif_ram.sv
// ----------------------------------------------------------------------------
// urif_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module urif_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

>>> src/urif_cmd_fifo.sv
// ----------------------------------------------------------------------------
// urif_cmd_fifo
// Short queue of read commands between the front and the back.
// ----------------------------------------------------------------------------
module urif_cmd_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  urif_pkg::t_rd_cmd   i_cmd,
    input  logic                i_pop,
    output urif_pkg::t_rd_cmd   o_cmd,
    output urif_pkg::t_cmdq_stat o_stat
);

    urif_pkg::t_rd_cmd                 r_q [urif_pkg::CMDQ_DEPTH];
    logic [urif_pkg::CMDQ_PTR_W-1:0]  r_wr_ptr;
    logic [urif_pkg::CMDQ_PTR_W-1:0]  r_rd_ptr;
    logic [urif_pkg::CMDQ_CNT_W-1:0]  r_cnt;
    logic [urif_pkg::CMDQ_CNT_W-1:0]  n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_cmd        = r_q[r_rd_ptr];
    assign o_stat.full  = (r_cnt == urif_pkg::CMDQ_CNT_W'(urif_pkg::CMDQ_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    a_no_push_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != urif_pkg::CMDQ_CNT_W'(urif_pkg::CMDQ_DEPTH)))
        else $error("command pushed into full queue");

    a_no_pop_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != '0))
        else $error("command popped from empty queue");

endmodule

>>> src/urif_front.sv
// ----------------------------------------------------------------------------
// urif_front
// Accepts requests: stores bytes, runs the idle timer, queues read commands.
// ----------------------------------------------------------------------------
module urif_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    urif_req_if.sink                     i_req,
    urif_cfg_if.sink                     i_cfg,
    input  urif_pkg::t_cmdq_stat         i_cmdq_stat,
    input  logic                         i_back_busy,
    output logic                         o_cmd_push,
    output urif_pkg::t_rd_cmd            o_cmd,
    output logic                         o_wr_en,
    output logic [urif_pkg::ADDR_W-1:0]  o_wr_addr,
    output logic [7:0]                   o_wr_data
);

    localparam int CMP_W = (urif_pkg::ADDR_W > urif_pkg::CNT_W) ?
                           urif_pkg::ADDR_W : urif_pkg::CNT_W;

    logic [urif_pkg::ADDR_W-1:0] r_write_ptr, n_write_ptr;
    logic [urif_pkg::ADDR_W-1:0] r_read_ptr,  n_read_ptr;
    logic [urif_pkg::ADDR_W-1:0] r_frame_end, n_frame_end;
    logic                        r_receiving, n_receiving;
    logic                        r_pending,   n_pending;
    logic [urif_pkg::IDLE_W-1:0] r_idle_cnt,  n_idle_cnt;
    logic [urif_pkg::IDLE_W-1:0] r_idle_limit;

    urif_pkg::t_req_type         req;
    logic                        accept;
    logic [urif_pkg::IDLE_W-1:0] idle_inc;
    logic                        near_full;
    logic [urif_pkg::ADDR_W-1:0] avail;
    logic [urif_pkg::CNT_W-1:0]  max_sat;
    logic [urif_pkg::CNT_W-1:0]  rd_count;

    assign req = urif_pkg::t_req_type'(i_req.req_type);

    // bytes wait until every queued read has fetched its data from the ring
    always_comb begin
        case (req)
            urif_pkg::REQ_BYTE: i_req.ready = i_cmdq_stat.empty && !i_back_busy;
            urif_pkg::REQ_READ: i_req.ready = !i_cmdq_stat.full;
            default:            i_req.ready = 1'b1;
        endcase
    end

    assign accept = i_req.valid && i_req.ready;

    assign idle_inc  = (r_idle_cnt == urif_pkg::IDLE_MAX) ? r_idle_cnt : r_idle_cnt + 1'b1;
    assign near_full = (urif_pkg::NF_W'(r_write_ptr) + urif_pkg::NF_W'(urif_pkg::NEAR_FULL_GAP))
                       == urif_pkg::NF_W'(r_read_ptr);
    assign avail     = r_frame_end - r_read_ptr;
    assign max_sat   = (i_req.max_read > urif_pkg::CNT_W'(urif_pkg::MAX_BURST)) ?
                       urif_pkg::CNT_W'(urif_pkg::MAX_BURST) : i_req.max_read;

    always_comb begin
        rd_count = '0;
        if (r_pending) begin
            rd_count = (CMP_W'(avail) > CMP_W'(max_sat)) ? max_sat : urif_pkg::CNT_W'(avail);
        end
    end

    always_comb begin
        n_write_ptr = r_write_ptr;
        n_read_ptr  = r_read_ptr;
        n_frame_end = r_frame_end;
        n_receiving = r_receiving;
        n_pending   = r_pending;
        n_idle_cnt  = r_idle_cnt;
        o_wr_en     = 1'b0;
        o_cmd_push  = 1'b0;
        if (accept) begin
            case (req)
                urif_pkg::REQ_BYTE: begin
                    o_wr_en     = 1'b1;
                    n_write_ptr = r_write_ptr + 1'b1;
                    n_receiving = 1'b1;
                    n_idle_cnt  = '0;
                end
                urif_pkg::REQ_TICK: begin
                    n_idle_cnt = idle_inc;
                    if ((idle_inc > r_idle_limit) &&
                        ((r_receiving && !r_pending) || near_full)) begin
                        n_pending   = 1'b1;
                        n_receiving = 1'b0;
                        n_frame_end = r_write_ptr;
                    end
                end
                urif_pkg::REQ_READ: begin
                    o_cmd_push = 1'b1;
                    n_pending  = 1'b0;
                    n_read_ptr = r_read_ptr + urif_pkg::ADDR_W'(rd_count);
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cmd.addr  = r_read_ptr;
    assign o_cmd.count = rd_count;
    assign o_wr_addr   = r_write_ptr;
    assign o_wr_data   = i_req.rx_byte;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_ptr  <= '0;
            r_read_ptr   <= '0;
            r_frame_end  <= '0;
            r_receiving  <= 1'b0;
            r_pending    <= 1'b0;
            r_idle_cnt   <= '0;
            r_idle_limit <= urif_pkg::IDLE_LIMIT_RST;
        end else begin
            r_write_ptr <= n_write_ptr;
            r_read_ptr  <= n_read_ptr;
            r_frame_end <= n_frame_end;
            r_receiving <= n_receiving;
            r_pending   <= n_pending;
            r_idle_cnt  <= n_idle_cnt;
            if (i_cfg.valid) begin
                r_idle_limit <= i_cfg.idle_limit;
            end
        end
    end

endmodule

>>> src/urif_back.sv
// ----------------------------------------------------------------------------
// urif_back
// Drains queued read commands from the ring, one byte per cycle while the output buffer has room.
// ----------------------------------------------------------------------------
module urif_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  urif_pkg::t_rd_cmd            i_cmd,
    input  urif_pkg::t_cmdq_stat         i_cmdq_stat,
    output logic                         o_cmd_pop,
    output logic                         o_busy,
    output logic                         o_rd_en,
    output logic [urif_pkg::ADDR_W-1:0]  o_rd_addr,
    input  logic [7:0]                   i_rd_data,
    urif_res_if.source                   o_res
);

    // issue side
    logic                        r_busy, n_busy;
    logic                        r_empty, n_empty;
    logic [urif_pkg::ADDR_W-1:0] r_addr, n_addr;
    logic [urif_pkg::CNT_W-1:0]  r_left, n_left;
    logic [urif_pkg::CNT_W-1:0]  r_total, n_total;

    // ram read in flight
    logic                        r_p1_valid;
    logic                        r_p1_has;
    logic                        r_p1_last;
    logic [urif_pkg::CNT_W-1:0]  r_p1_total;

    // two-entry output buffer
    urif_pkg::t_result           r_ob [2];
    logic                        r_ob_wr;
    logic                        r_ob_rd;
    logic [1:0]                  r_ob_cnt;

    logic                        pop_out;
    logic                        issue;
    logic                        issue_last;
    urif_pkg::t_result           p1_res;

    assign pop_out    = o_res.valid && o_res.ready;
    // a slot must be free for the read when its data arrives
    assign issue      = r_busy &&
                        ((3'(r_ob_cnt) + 3'(r_p1_valid) - 3'(pop_out)) < 3'd2);
    assign issue_last = r_empty || (r_left == urif_pkg::CNT_W'(1));

    always_comb begin
        n_busy    = r_busy;
        n_empty   = r_empty;
        n_addr    = r_addr;
        n_left    = r_left;
        n_total   = r_total;
        o_cmd_pop = 1'b0;
        if (!r_busy) begin
            if (!i_cmdq_stat.empty) begin
                o_cmd_pop = 1'b1;
                n_busy    = 1'b1;
                n_addr    = i_cmd.addr;
                n_left    = i_cmd.count;
                n_total   = i_cmd.count;
                n_empty   = (i_cmd.count == '0);
            end
        end else if (issue) begin
            n_addr = r_addr + 1'b1;
            n_left = r_left - 1'b1;
            if (issue_last) begin
                n_busy = 1'b0;
            end
        end
    end

    assign o_busy    = r_busy;
    assign o_rd_en   = issue && !r_empty;
    assign o_rd_addr = r_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_p1_valid <= 1'b0;
            r_ob_wr    <= 1'b0;
            r_ob_rd    <= 1'b0;
            r_ob_cnt   <= '0;
        end else begin
            r_busy     <= n_busy;
            r_p1_valid <= issue;
            if (r_p1_valid) begin
                r_ob_wr <= ~r_ob_wr;
            end
            if (pop_out) begin
                r_ob_rd <= ~r_ob_rd;
            end
            r_ob_cnt <= r_ob_cnt + 2'(r_p1_valid) - 2'(pop_out);
        end
    end

    always_ff @(posedge i_clk) begin
        r_empty <= n_empty;
        r_addr  <= n_addr;
        r_left  <= n_left;
        r_total <= n_total;
        if (issue) begin
            r_p1_has   <= !r_empty;
            r_p1_last  <= issue_last;
            r_p1_total <= r_total;
        end
        if (r_p1_valid) begin
            r_ob[r_ob_wr] <= p1_res;
        end
    end

    assign p1_res.out_byte     = r_p1_has ? i_rd_data : 8'd0;
    assign p1_res.has_byte     = r_p1_has;
    assign p1_res.last_of_read = r_p1_last;
    assign p1_res.read_total   = r_p1_total;

    assign o_res.valid        = (r_ob_cnt != '0);
    assign o_res.out_byte     = r_ob[r_ob_rd].out_byte;
    assign o_res.has_byte     = r_ob[r_ob_rd].has_byte;
    assign o_res.last_of_read = r_ob[r_ob_rd].last_of_read;
    assign o_res.read_total   = r_ob[r_ob_rd].read_total;

    a_ob_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1_valid |-> ((r_ob_cnt != 2'd2) || pop_out))
        else $error("output buffer overflow");

    a_burst_count_live : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_empty) |-> (r_left != '0))
        else $error("burst running with no bytes left");

endmodule

>>> src/uart_rx_ring_idle_framer.sv
// ----------------------------------------------------------------------------
// uart_rx_ring_idle_framer
// Receive ring buffer that closes frames after a programmable line idle time.
// ----------------------------------------------------------------------------
// byte and tick transactions update registered state, one per cycle when ready
// read: queued commands go to the back, which reads the ring read port and gives
//   one result per cycle while the output buffer has room
// byte transactions stall while queued reads still fetch from the ring
// reset (synchronous, active low) clears pointers, flags and idle counter and
//   loads idle_limit with 93333; ring contents are not cleared
module uart_rx_ring_idle_framer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    urif_req_if.sink   i_req,
    urif_cfg_if.sink   i_cfg,
    urif_res_if.source o_res
);

    logic                        cmd_push;
    logic                        cmd_pop;
    urif_pkg::t_rd_cmd           cmd_in;
    urif_pkg::t_rd_cmd           cmd_out;
    urif_pkg::t_cmdq_stat        cmdq_stat;
    logic                        back_busy;
    logic                        wr_en;
    logic [urif_pkg::ADDR_W-1:0] wr_addr;
    logic [7:0]                  wr_data;
    logic                        rd_en;
    logic [urif_pkg::ADDR_W-1:0] rd_addr;
    logic [7:0]                  rd_data;

    urif_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg       (i_cfg),
        .i_cmdq_stat (cmdq_stat),
        .i_back_busy (back_busy),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    urif_cmd_fifo u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .i_pop   (cmd_pop),
        .o_cmd   (cmd_out),
        .o_stat  (cmdq_stat)
    );

    urif_ram #(
        .WIDTH (8),
        .DEPTH (urif_pkg::RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    urif_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_out),
        .i_cmdq_stat (cmdq_stat),
        .o_cmd_pop   (cmd_pop),
        .o_busy      (back_busy),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_res       (o_res)
    );

endmodule
